// ----- rtl/hidx_pkg.sv -----
// shared constants and control word type for the hilbert index to xy block
// no dependencies
`default_nettype none

package hidx_pkg;

  localparam int MAX_ORDER_DEF = 8;
  localparam int FRAC_BITS_DEF = 4;

  localparam int IDX_W   = 16;
  localparam int STEP_W  = 4;
  localparam int POS_W   = 12;
  localparam int ORDER_W = 4;

  localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd4;

  // control that travels with each word down the pipeline
  typedef struct packed {
    logic              valid;
    logic              oor;
    logic [STEP_W-1:0] frac;
  } hidx_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/hilbert_index_to_xy_interp.sv -----
// hilbert index to interpolated xy, registered in stages (prep, one
// stage per curve level, blend and output register); one word per cycle
// the whole pipeline holds while the output word waits, so nothing is dropped
// reset clears all valid bits and sets the curve order to 4
// depends on hidx_pkg and hidx_level
`default_nettype none

module hilbert_index_to_xy_interp
  import hidx_pkg::*;
#(
  parameter int MAX_ORDER = MAX_ORDER_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [ORDER_W-1:0] cfg_curve_order,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [IDX_W-1:0]   in_curve_index,
  input  wire logic [STEP_W-1:0]  in_step_fraction,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [POS_W-1:0]        out_x_pos,
  output logic [POS_W-1:0]        out_y_pos,
  output logic                    out_index_out_of_range
);

  localparam int CW   = MAX_ORDER;
  localparam int IDXW = 2 * MAX_ORDER;
  localparam int SW   = CW + FRAC_BITS + 1;

  logic [ORDER_W-1:0] order_r;
  logic [4:0]         ord_eff;
  logic [5:0]         ord2;
  logic               advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORDER_RESET;
    end else if (cfg_valid) begin
      order_r <= cfg_curve_order;
    end
  end

  always_comb begin
    if (order_r == '0) begin
      ord_eff = 5'd1;
    end else if ({1'b0, order_r} > 5'(MAX_ORDER)) begin
      ord_eff = 5'(MAX_ORDER);
    end else begin
      ord_eff = {1'b0, order_r};
    end
    ord2 = {ord_eff, 1'b0};
  end

  logic out_valid_r;
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = advance;

  // prep stage: range check, clamp, next index, fraction
  logic [IDX_W-1:0]  lim16;
  logic [IDXW-1:0]   last_w;
  logic [IDX_W-1:0]  idx_c;
  logic [IDXW-1:0]   idx_w;
  logic [STEP_W-1:0] frac_m;
  logic              oor;
  logic              is_last;
  hidx_ctl_t         ctl_nxt;

  always_comb begin
    for (int i = 0; i < IDX_W; i++) begin
      lim16[i] = (6'(i) < ord2);
    end
    for (int i = 0; i < IDXW; i++) begin
      last_w[i] = (6'(i) < ord2);
    end
    for (int i = 0; i < STEP_W; i++) begin
      frac_m[i] = in_step_fraction[i] && (i < FRAC_BITS);
    end
    oor     = |(in_curve_index & ~lim16);
    idx_c   = oor ? lim16 : in_curve_index;
    idx_w   = IDXW'(idx_c);
    is_last = (idx_w == last_w);
    ctl_nxt.valid = in_valid;
    ctl_nxt.oor   = oor;
    // at the last point the next point is the same, so the fraction drops out
    ctl_nxt.frac  = is_last ? '0 : frac_m;
  end

  hidx_ctl_t       ctl_s [0:MAX_ORDER];
  logic [IDXW-1:0] i0_s  [0:MAX_ORDER];
  logic [IDXW-1:0] i1_s  [0:MAX_ORDER];
  logic [CW-1:0]   x0_s  [0:MAX_ORDER];
  logic [CW-1:0]   y0_s  [0:MAX_ORDER];
  logic [CW-1:0]   x1_s  [0:MAX_ORDER];
  logic [CW-1:0]   y1_s  [0:MAX_ORDER];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_s[0].valid <= 1'b0;
    end else if (advance) begin
      ctl_s[0].valid <= ctl_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ctl_s[0].oor  <= ctl_nxt.oor;
      ctl_s[0].frac <= ctl_nxt.frac;
      i0_s[0]       <= idx_w;
      i1_s[0]       <= idx_w + IDXW'(1);
    end
  end

  assign x0_s[0] = '0;
  assign y0_s[0] = '0;
  assign x1_s[0] = '0;
  assign y1_s[0] = '0;

  for (genvar l = 0; l < MAX_ORDER; l++) begin : g_level
    logic active;
    assign active = (ord_eff > 5'(l));

    hidx_level #(
      .CW   (CW),
      .IDXW (IDXW),
      .LVL  (l)
    ) u_level (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .active  (active),
      .ctl_in  (ctl_s[l]),
      .i0_in   (i0_s[l]),
      .i1_in   (i1_s[l]),
      .x0_in   (x0_s[l]),
      .y0_in   (y0_s[l]),
      .x1_in   (x1_s[l]),
      .y1_in   (y1_s[l]),
      .ctl_r   (ctl_s[l+1]),
      .i0_r    (i0_s[l+1]),
      .i1_r    (i1_s[l+1]),
      .x0_r    (x0_s[l+1]),
      .y0_r    (y0_s[l+1]),
      .x1_r    (x1_s[l+1]),
      .y1_r    (y1_s[l+1])
    );
  end

  // blend: neighbours differ by one unit, so step by the fraction toward the next point
  function automatic logic [POS_W-1:0] blend(logic [CW-1:0] a, logic [CW-1:0] b,
                                             logic [STEP_W-1:0] f);
    logic [SW-1:0] base;
    logic [SW-1:0] fe;
    logic [SW-1:0] r;
    base = SW'(a) << FRAC_BITS;
    fe   = SW'(f);
    if (b > a) begin
      r = base + fe;
    end else if (b < a) begin
      r = base - fe;
    end else begin
      r = base;
    end
    return POS_W'(r);
  endfunction

  logic [POS_W-1:0] x_pos_r, y_pos_r;
  logic             oor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= ctl_s[MAX_ORDER].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      x_pos_r <= blend(x0_s[MAX_ORDER], x1_s[MAX_ORDER], ctl_s[MAX_ORDER].frac);
      y_pos_r <= blend(y0_s[MAX_ORDER], y1_s[MAX_ORDER], ctl_s[MAX_ORDER].frac);
      oor_r   <= ctl_s[MAX_ORDER].oor;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_x_pos              = x_pos_r;
  assign out_y_pos              = y_pos_r;
  assign out_index_out_of_range = oor_r;

  // index registers of the last level feed nothing further
  logic unused_idx;
  assign unused_idx = ^{i0_s[MAX_ORDER], i1_s[MAX_ORDER]};

endmodule

`default_nettype wire

// ----- rtl/hidx_level.sv -----
// one registered level of the hilbert d2xy rotate/reflect walk, for both points
// depends on hidx_pkg
`default_nettype none

module hidx_level
  import hidx_pkg::*;
#(
  parameter int CW   = MAX_ORDER_DEF,
  parameter int IDXW = 2 * MAX_ORDER_DEF,
  parameter int LVL  = 0
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            advance,
  input  wire logic            active,
  input  wire hidx_ctl_t       ctl_in,
  input  wire logic [IDXW-1:0] i0_in,
  input  wire logic [IDXW-1:0] i1_in,
  input  wire logic [CW-1:0]   x0_in,
  input  wire logic [CW-1:0]   y0_in,
  input  wire logic [CW-1:0]   x1_in,
  input  wire logic [CW-1:0]   y1_in,
  output hidx_ctl_t            ctl_r,
  output logic      [IDXW-1:0] i0_r,
  output logic      [IDXW-1:0] i1_r,
  output logic      [CW-1:0]   x0_r,
  output logic      [CW-1:0]   y0_r,
  output logic      [CW-1:0]   x1_r,
  output logic      [CW-1:0]   y1_r
);

  // low LVL bits set: reflect within the current sub-square
  localparam logic [CW-1:0] LMASK = {CW{1'b1}} >> (CW - LVL);

  function automatic logic [2*CW-1:0] step_pt(logic [CW-1:0] x, logic [CW-1:0] y,
                                              logic qx, logic qy);
    logic [CW-1:0] xs;
    logic [CW-1:0] ys;
    logic [CW-1:0] tmp;
    xs = x;
    ys = y;
    if (!qy) begin
      if (qx) begin
        xs = xs ^ LMASK;
        ys = ys ^ LMASK;
      end
      tmp = xs;
      xs  = ys;
      ys  = tmp;
    end
    // coordinates are below 2^LVL here, so the add is an or
    xs = xs | (CW'(qx) << LVL);
    ys = ys | (CW'(qy) << LVL);
    return {xs, ys};
  endfunction

  logic            qx0, qy0, qx1, qy1;
  logic [2*CW-1:0] p0_nxt, p1_nxt;

  always_comb begin
    qx0 = i0_in[2*LVL+1];
    qy0 = i0_in[2*LVL] ^ qx0;
    qx1 = i1_in[2*LVL+1];
    qy1 = i1_in[2*LVL] ^ qx1;
    if (active) begin
      p0_nxt = step_pt(x0_in, y0_in, qx0, qy0);
      p1_nxt = step_pt(x1_in, y1_in, qx1, qy1);
    end else begin
      p0_nxt = {x0_in, y0_in};
      p1_nxt = {x1_in, y1_in};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (advance) begin
      ctl_r.valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ctl_r.oor  <= ctl_in.oor;
      ctl_r.frac <= ctl_in.frac;
      i0_r       <= i0_in;
      i1_r       <= i1_in;
      {x0_r, y0_r} <= p0_nxt;
      {x1_r, y1_r} <= p1_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- verif/tb_hilbert_index_to_xy_interp.sv -----
// self-checking bench for hilbert_index_to_xy_interp: directed and random curve indices
// under several curve orders, results checked against an in-bench d2xy predictor
// depends on hidx_pkg and the hilbert_index_to_xy_interp rtl
`default_nettype none

module tb_hilbert_index_to_xy_interp
  import hidx_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned TAIL_CYCLES = MAX_ORDER_DEF + 6;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic             oor;
  } hilbert_pos_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [ORDER_W-1:0] cfg_curve_order = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [IDX_W-1:0]   in_curve_index = '0;
  logic [STEP_W-1:0]  in_step_fraction = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [POS_W-1:0]   out_x_pos;
  logic [POS_W-1:0]   out_y_pos;
  logic               out_index_out_of_range;

  hilbert_pos_t       pos_expected[$];
  hilbert_pos_t       want_pos;
  logic [ORDER_W-1:0] cur_order = ORDER_RESET;
  int unsigned        send_idle_pct = 0;
  int unsigned        recv_idle_pct = 0;
  int unsigned        err_count = 0;
  int unsigned        quiet_cycles = 0;

  hilbert_index_to_xy_interp DUT (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_curve_order        (cfg_curve_order),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_curve_index         (in_curve_index),
    .in_step_fraction       (in_step_fraction),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_x_pos              (out_x_pos),
    .out_y_pos              (out_y_pos),
    .out_index_out_of_range (out_index_out_of_range)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned effective_order(input logic [ORDER_W-1:0] order_reg);
    int unsigned ord;
    ord = 32'(order_reg);
    if (ord < 1) ord = 1;
    if (ord > MAX_ORDER_DEF) ord = MAX_ORDER_DEF;
    return ord;
  endfunction

  // d2xy, smallest square first: quadrant bits pick rotate/reflect, then offset
  function automatic void curve_point(input int unsigned order, input int unsigned index,
                                      output int unsigned px, output int unsigned py);
    int unsigned x, y, t, s, qx, qy, tmp;
    x = 0;
    y = 0;
    t = index;
    for (int unsigned lvl = 0; lvl < order; lvl++) begin
      s  = 1 << lvl;
      qx = (t >> 1) & 1;
      qy = (t ^ qx) & 1;
      if (qy == 0) begin
        if (qx == 1) begin
          x = s - 1 - x;
          y = s - 1 - y;
        end
        tmp = x;
        x = y;
        y = tmp;
      end
      x += s * qx;
      y += s * qy;
      t >>= 2;
    end
    px = x;
    py = y;
  endfunction

  // neighbours are one unit apart, so the blend is an add or subtract of the fraction
  function automatic logic [POS_W-1:0] lerp_coord(input int unsigned a, input int unsigned b,
                                                  input int unsigned frac);
    int unsigned base;
    base = a << FRAC_BITS_DEF;
    if (b > a) base = base + frac;
    else if (b < a) base = base - frac;
    return base[POS_W-1:0];
  endfunction

  function automatic hilbert_pos_t predict_pos(input logic [ORDER_W-1:0] order_reg,
                                               input logic [IDX_W-1:0] index,
                                               input logic [STEP_W-1:0] step);
    hilbert_pos_t res;
    int unsigned  ord, count, idx, frac, x0, y0, x1, y1;
    ord     = effective_order(order_reg);
    count   = 1 << (2 * ord);
    idx     = 32'(index);
    frac    = 32'(step);
    res.oor = 1'b0;
    if (idx >= count) begin
      res.oor = 1'b1;
      idx     = count - 1;
      frac    = 0;
    end
    curve_point(ord, idx, x0, y0);
    if (idx + 1 < count) begin
      curve_point(ord, idx + 1, x1, y1);
    end else begin
      x1 = x0;
      y1 = y0;
    end
    res.x = lerp_coord(x0, x1, frac);
    res.y = lerp_coord(y0, y1, frac);
    return res;
  endfunction

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    $display("ERROR at %0t: %s got %0d, want %0d", $time, field, got, want);
    err_count++;
  endtask

  // one word into the block; the expectation is queued at the accepting edge
  task automatic send_word(input logic [IDX_W-1:0] index, input logic [STEP_W-1:0] step);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_curve_index   <= index;
    in_step_fraction <= step;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pos_expected.push_back(predict_pos(cur_order, index, step));
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pos_expected.size() != 0) @(posedge clk);
  endtask

  task automatic set_curve_order(input logic [ORDER_W-1:0] order_val);
    wait_drain();
    cfg_valid       <= 1'b1;
    cfg_curve_order <= order_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_order = order_val;
  endtask

  // reset order of 4: corners of the index range, last index and just past it
  task automatic test_reset_order();
    send_word(16'd0, 4'd0);
    send_word(16'd0, 4'd15);
    send_word(16'd1, 4'd8);
    send_word(16'd254, 4'd15);
    send_word(16'd255, 4'd15);
    send_word(16'd256, 4'd7);
    send_word(16'hFFFF, 4'd15);
    send_word(16'hAAAA, 4'd5);
    send_word(16'h0055, 4'd10);
  endtask

  // order 0 behaves as 1, anything above the maximum behaves as the maximum
  task automatic test_order_clamping();
    set_curve_order(4'd0);
    send_word(16'd0, 4'd15);
    send_word(16'd1, 4'd8);
    send_word(16'd2, 4'd15);
    send_word(16'd3, 4'd15);
    send_word(16'd4, 4'd3);
    set_curve_order(4'd15);
    send_word(16'd65534, 4'd15);
    send_word(16'd65535, 4'd15);
    set_curve_order(MAX_ORDER_DEF[ORDER_W-1:0]);
    send_word(16'd0, 4'd1);
    send_word(16'd32767, 4'd15);
    send_word(16'd65535, 4'd9);
    set_curve_order(4'd1);
    send_word(16'd0, 4'd15);
    send_word(16'd3, 4'd2);
    send_word(16'd1000, 4'd11);
  endtask

  task automatic test_random_indices(input int unsigned s_idle, input int unsigned r_idle,
                                     input int unsigned phase_no);
    int unsigned count, pick, idx;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int unsigned k = 0; k < 6; k++) begin
      set_curve_order(ORDER_W'((phase_no * 6 + k) % 16));
      count = 1 << (2 * effective_order(cur_order));
      for (int unsigned n = 0; n < 30; n++) begin
        pick = $urandom_range(99);
        if (pick < 75) idx = $urandom_range(count - 1);
        else if (pick < 85) idx = $urandom_range(count - 1, count - 2);
        else if (pick < 92) idx = (count > 65535) ? 65535 : count;
        else idx = $urandom_range(65535);
        send_word(idx[IDX_W-1:0], STEP_W'($urandom_range(15)));
        // sender holds off once per order until the pipe is empty
        if (n == 15) wait_drain();
      end
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_valid && out_ready) begin
      if (pos_expected.size() == 0) begin
        report_mismatch("unexpected word, x_pos", 32'(out_x_pos), 0);
      end else begin
        want_pos = pos_expected.pop_front();
        if (out_x_pos !== want_pos.x)
          report_mismatch("x_pos", 32'(out_x_pos), 32'(want_pos.x));
        if (out_y_pos !== want_pos.y)
          report_mismatch("y_pos", 32'(out_y_pos), 32'(want_pos.y));
        if (out_index_out_of_range !== want_pos.oor)
          report_mismatch("index_out_of_range", 32'(out_index_out_of_range),
                          32'(want_pos.oor));
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_order();
    test_order_clamping();
    test_random_indices(36, 77, 0);
    test_random_indices(77, 36, 1);
    test_random_indices(0, 0, 2);
    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
